// ===== src/slk_pkg.sv =====
// Shared types and constants for the spherical log kernel direct-sum core.
package slk_pkg;
    localparam int MAX_SOURCES = 256;
    localparam int IDX_W = $clog2(MAX_SOURCES);
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam int OP_W = 33;
    localparam int PROD_W = 2 * OP_W;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
    localparam logic [31:0] INV4PI_Q32 = 32'h145F306E;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic               first_source;
        logic [19:0]        point_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        point_area;
        logic signed [31:0] point_potential;
        logic signed [63:0] prior_sum;
    } t_in;

    typedef struct packed {
        logic [19:0]        target_id;
        logic signed [63:0] total;
    } t_out;

    typedef struct packed {
        logic [19:0]        id;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        area;
        logic signed [31:0] pot;
    } t_src;
endpackage

// ===== src/slk_mul.sv =====
// Shared registered signed multiplier used by every multiply step.
module slk_mul
    import slk_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [OP_W-1:0]   i_opa,
    input  logic signed [OP_W-1:0]   i_opb,
    output logic signed [PROD_W-1:0] o_prod
);
    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_opa * i_opb;
    end

    assign o_prod = r_prod;
endmodule

// ===== src/sphere_log_kernel_direct_sum.sv =====
// Top level: source store, kernel sequencer and saturating accumulator.
// Direct-sum evaluator of G(t,s) = -ln(1 - t.s)/(4*pi) over stored sources.
// A load beat (cmd 0) appends a source; first_source empties the store
// first, and a load into a full store is dropped. An evaluate beat (cmd 1)
// walks every stored source in order through one shared 33x33 registered
// multiplier, skips the source with the target's own id, and returns one
// result beat. Per non-skipped source the walk runs fetch and id compare,
// dot product and clamp, leading-one normalize, 32 squarings, log scaling,
// kernel, area times potential, four partial products, then accumulate and
// advance. Posting the result waits while the previous result is still
// stalled. The input is stalled for the whole walk; a load is taken only
// when no evaluate is in progress.
module sphere_log_kernel_direct_sum_core
    import slk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_FETCH = 5'd1;
    localparam logic [4:0] ST_CHECK = 5'd2;
    localparam logic [4:0] ST_DY    = 5'd3;
    localparam logic [4:0] ST_DZ    = 5'd4;
    localparam logic [4:0] ST_DEND  = 5'd5;
    localparam logic [4:0] ST_NORM  = 5'd6;
    localparam logic [4:0] ST_SQ    = 5'd7;
    localparam logic [4:0] ST_SQW   = 5'd8;
    localparam logic [4:0] ST_LOG   = 5'd9;
    localparam logic [4:0] ST_LN0   = 5'd10;
    localparam logic [4:0] ST_LN1   = 5'd11;
    localparam logic [4:0] ST_LN2   = 5'd12;
    localparam logic [4:0] ST_G1    = 5'd13;
    localparam logic [4:0] ST_G2    = 5'd14;
    localparam logic [4:0] ST_AP    = 5'd15;
    localparam logic [4:0] ST_PP    = 5'd16;
    localparam logic [4:0] ST_PPW   = 5'd17;
    localparam logic [4:0] ST_ACC   = 5'd18;
    localparam logic [4:0] ST_NEXT  = 5'd19;
    localparam logic [4:0] ST_DONE  = 5'd20;
    localparam logic [4:0] ST_G0    = 5'd21;

    t_src mem [MAX_SOURCES];
    t_src r_rd;

    logic [4:0]          r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_j;
    logic [19:0]         r_tid;
    logic signed [31:0]  r_tx, r_ty, r_tz;
    logic signed [63:0]  r_tot;
    logic signed [63:0]  r_dot;
    logic [62:0]         r_a;
    logic [5:0]          r_sh;
    logic [31:0]         r_m;
    logic [31:0]         r_f;
    logic [4:0]          r_k;
    logic [39:0]         r_lm;
    logic [31:0]         r_acc;
    logic [39:0]         r_ln;
    logic [39:0]         r_g;
    logic [63:0]         r_ap;
    logic [107:0]        r_pp;
    logic                r_out_valid;
    t_out                r_out;

    logic signed [OP_W-1:0]   opa, opb;
    logic signed [PROD_W-1:0] prod;
    logic                     in_acc;
    logic [CNT_W-1:0]         load_cnt;
    logic signed [63:0]       arg;
    logic [32:0]              sq;
    logic [5:0]               lm_d;
    logic [39:0]              lm_base, lm;
    logic [31:0]              potmag;
    logic                     neg;
    logic [63:0]              c;
    logic signed [65:0]       sum;
    logic [127:0]             pp_add;
    logic [CNT_W-1:0]         j_inc;

    slk_mul u_mul (
        .i_clk  (i_clk),
        .i_opa  (opa),
        .i_opb  (opb),
        .o_prod (prod)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign load_cnt    = i_in_data.first_source ? '0 : r_count;
    assign j_inc       = r_j + 1'b1;

    assign potmag = r_rd.pot[31] ? 32'(-r_rd.pot) : 32'(r_rd.pot);
    // kernel sign is positive when the log is negative (argument below one)
    assign neg    = (r_sh <= 6'd4) ^ r_rd.pot[31];
    assign c      = r_pp[107:44];
    assign sum    = neg ? ($signed({{2{r_tot[63]}}, r_tot}) - $signed({2'b00, c}))
                        : ($signed({{2{r_tot[63]}}, r_tot}) + $signed({2'b00, c}));
    assign arg    = (64'sd1 <<< 58) - (r_dot + $signed(prod[65:2]));
    assign sq     = prod[63:31];

    assign lm_d    = (r_sh > 6'd4) ? (r_sh - 6'd4) : (6'd4 - r_sh);
    assign lm_base = {2'b00, lm_d, 32'h0};
    assign lm      = (r_sh > 6'd4) ? (lm_base - {8'h0, r_f}) : (lm_base + {8'h0, r_f});

    // shift each partial product to its place: low, 32 up, or 64 up
    always_comb begin
        unique case ({r_k[1], r_k[0]})
            2'b00:   pp_add = {64'h0, prod[63:0]};
            2'b11:   pp_add = {prod[63:0], 64'h0};
            default: pp_add = {32'h0, prod[63:0], 32'h0};
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        opa = '0;
        opb = '0;
        unique case (r_state)
            ST_CHECK: begin
                opa = {r_tx[31], r_tx};
                opb = {r_rd.x[31], r_rd.x};
            end
            ST_DY: begin
                opa = {r_ty[31], r_ty};
                opb = {r_rd.y[31], r_rd.y};
            end
            ST_DZ: begin
                opa = {r_tz[31], r_tz};
                opb = {r_rd.z[31], r_rd.z};
            end
            ST_SQ: begin
                opa = {1'b0, r_m};
                opb = {1'b0, r_m};
            end
            ST_LN0: begin
                opa = {1'b0, r_lm[31:0]};
                opb = {1'b0, LN2_Q32};
            end
            ST_LN1: begin
                opa = {25'h0, r_lm[39:32]};
                opb = {1'b0, LN2_Q32};
            end
            ST_G0: begin
                opa = {1'b0, r_ln[31:0]};
                opb = {1'b0, INV4PI_Q32};
            end
            ST_G1: begin
                opa = {25'h0, r_ln[39:32]};
                opb = {1'b0, INV4PI_Q32};
            end
            ST_G2: begin
                opa = {1'b0, r_rd.area};
                opb = {1'b0, potmag};
            end
            ST_PP: begin
                opa = {1'b0, (r_k[0] ? r_ap[63:32] : r_ap[31:0])};
                opb = {1'b0, (r_k[1] ? {24'h0, r_g[39:32]} : r_g[31:0])};
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // source store
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.cmd == CMD_LOAD) && (load_cnt < CNT_W'(MAX_SOURCES))) begin
            mem[load_cnt[IDX_W-1:0]] <= '{id: i_in_data.point_id, x: i_in_data.pos_x,
                                         y: i_in_data.pos_y, z: i_in_data.pos_z,
                                         area: i_in_data.point_area,
                                         pot: i_in_data.point_potential};
        end
        r_rd <= mem[r_j[IDX_W-1:0]];
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.cmd == CMD_LOAD) begin
                            if (load_cnt < CNT_W'(MAX_SOURCES)) begin
                                r_count <= load_cnt + 1'b1;
                            end else begin
                                r_count <= load_cnt;
                            end
                        end else begin
                            r_tid <= i_in_data.point_id;
                            r_tx  <= i_in_data.pos_x;
                            r_ty  <= i_in_data.pos_y;
                            r_tz  <= i_in_data.pos_z;
                            r_tot <= i_in_data.prior_sum;
                            r_j   <= '0;
                            r_state <= (r_count == '0) ? ST_DONE : ST_FETCH;
                        end
                    end
                end
                ST_FETCH: r_state <= ST_CHECK;
                ST_CHECK: begin
                    // drop the self-interaction
                    r_dot   <= '0;
                    r_state <= (r_rd.id == r_tid) ? ST_NEXT : ST_DY;
                end
                ST_DY: begin
                    r_dot   <= r_dot + $signed(prod[65:2]);
                    r_state <= ST_DZ;
                end
                ST_DZ: begin
                    r_dot   <= r_dot + $signed(prod[65:2]);
                    r_state <= ST_DEND;
                end
                ST_DEND: begin
                    // clamp a tiny or negative argument to one LSB
                    r_a     <= (arg <= 64'sd1) ? 63'd1 : arg[62:0];
                    r_sh    <= '0;
                    r_state <= ST_NORM;
                end
                ST_NORM: begin
                    priority if (r_a[62:55] == 8'h0) begin
                        r_a  <= r_a << 8;
                        r_sh <= r_sh + 6'd8;
                    end else if (!r_a[62]) begin
                        r_a  <= r_a << 1;
                        r_sh <= r_sh + 6'd1;
                    end else begin
                        r_m     <= r_a[62:31];
                        r_k     <= '0;
                        r_f     <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: r_state <= ST_SQW;
                ST_SQW: begin
                    // shift in one fraction bit of log2, MSB first
                    r_f <= {r_f[30:0], sq[32]};
                    r_m <= sq[32] ? sq[32:1] : sq[31:0];
                    r_k <= r_k + 1'b1;
                    r_state <= (r_k == 5'd31) ? ST_LOG : ST_SQ;
                end
                ST_LOG: begin
                    r_lm    <= lm;
                    r_state <= ST_LN0;
                end
                ST_LN0: r_state <= ST_LN1;
                ST_LN1: begin
                    r_acc   <= prod[63:32];
                    r_state <= ST_LN2;
                end
                ST_LN2: begin
                    r_ln    <= {8'h0, r_acc} + prod[39:0];
                    r_state <= ST_G0;
                end
                ST_G0: r_state <= ST_G1;
                ST_G1: begin
                    r_acc   <= prod[63:32];
                    r_state <= ST_G2;
                end
                ST_G2: begin
                    r_g     <= {8'h0, r_acc} + prod[39:0];
                    r_state <= ST_AP;
                end
                ST_AP: begin
                    r_ap    <= prod[63:0];
                    r_pp    <= '0;
                    r_k     <= '0;
                    r_state <= ST_PP;
                end
                ST_PP: r_state <= ST_PPW;
                ST_PPW: begin
                    r_pp    <= r_pp + pp_add[107:0];
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k[1:0] == 2'd3) ? ST_ACC : ST_PP;
                end
                ST_ACC: begin
                    priority if (sum > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
                        r_tot <= 64'sh7FFF_FFFF_FFFF_FFFF;
                    end else if (sum < -66'sh0_8000_0000_0000_0000) begin
                        r_tot <= 64'sh8000_0000_0000_0000;
                    end else begin
                        r_tot <= sum[63:0];
                    end
                    r_state <= ST_NEXT;
                end
                ST_NEXT: begin
                    if (j_inc >= r_count) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_j     <= j_inc;
                        r_state <= ST_FETCH;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{target_id: r_tid, total: r_tot};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_fetch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_j < r_count))
        else $error("source index beyond store fill");
    a_norm_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> r_m[31] || (r_k != 5'd0))
        else $error("mantissa not normalized");
    a_square_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQW) |-> (prod[65:64] == 2'b00))
        else $error("square overflowed");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");
endmodule
